>>> sv/ima_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ima_pkg
// Shared widths, operation codes, controller commands and helper functions
// for the integer math ALU.
// ----------------------------------------------------------------------------
package ima_pkg;

    localparam int DW    = 32;
    localparam int CNT_W = $clog2(DW);
    localparam int K_W   = $clog2(DW) + 1;

    localparam logic [4:0] OP_ADD      = 5'd0;
    localparam logic [4:0] OP_SUB      = 5'd1;
    localparam logic [4:0] OP_MUL      = 5'd2;
    localparam logic [4:0] OP_DIV      = 5'd3;
    localparam logic [4:0] OP_DIVFLOOR = 5'd4;
    localparam logic [4:0] OP_DIVCEIL  = 5'd5;
    localparam logic [4:0] OP_DIVROUND = 5'd6;
    localparam logic [4:0] OP_POW      = 5'd7;
    localparam logic [4:0] OP_MADD     = 5'd8;
    localparam logic [4:0] OP_FMOD     = 5'd9;
    localparam logic [4:0] OP_MOD      = 5'd10;
    localparam logic [4:0] OP_ABS      = 5'd11;
    localparam logic [4:0] OP_SIGN     = 5'd12;
    localparam logic [4:0] OP_MIN      = 5'd13;
    localparam logic [4:0] OP_MAX      = 5'd14;
    localparam logic [4:0] OP_GCD      = 5'd15;
    localparam logic [4:0] OP_LCM      = 5'd16;
    localparam logic [4:0] OP_NEG      = 5'd17;

    typedef enum logic [1:0] {
        CLS_SIMPLE,
        CLS_MUL,
        CLS_DIV,
        CLS_POW
    } t_cls_base;

    typedef enum logic [2:0] {
        C_SIMPLE,
        C_MUL,
        C_DIV,
        C_POW,
        C_GCD
    } t_cls;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SIMPLE_OUT,
        CMD_MUL,
        CMD_MADD_OUT,
        CMD_DIV_STEP,
        CMD_DIV_FIX,
        CMD_DIV_OUT,
        CMD_POW_STEP,
        CMD_POW_OUT,
        CMD_GCD_STEP,
        CMD_GCD_OUT,
        CMD_LCM_PREP,
        CMD_LCM_MUL,
        CMD_LCM_OUT
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SIMPLE,
        S_MUL,
        S_MADD,
        S_DIV,
        S_FIX,
        S_DOUT,
        S_POW,
        S_POUT,
        S_GCD,
        S_GOUT,
        S_LPREP,
        S_LDIV,
        S_LMUL,
        S_LOUT
    } t_state;

    typedef struct packed {
        t_cls cls;
        logic is_lcm;
        logic gcd_done;
    } t_status;

    function automatic t_cls op_class(input logic [4:0] op);
        t_cls c;
        c = C_SIMPLE;
        case (op) inside
            OP_MUL, OP_MADD: c = C_MUL;
            OP_DIV, OP_DIVFLOOR, OP_DIVCEIL, OP_DIVROUND, OP_FMOD, OP_MOD: c = C_DIV;
            OP_POW: c = C_POW;
            OP_GCD, OP_LCM: c = C_GCD;
            default: c = C_SIMPLE;
        endcase
        return c;
    endfunction

    function automatic logic [DW-1:0] mag(input logic [DW-1:0] x);
        return x[DW-1] ? (DW'(0) - x) : x;
    endfunction

    function automatic logic [DW-1:0] sgn(input logic neg, input logic [DW-1:0] m);
        return neg ? (DW'(0) - m) : m;
    endfunction

endpackage
`default_nettype wire

>>> sv/integer_math_alu_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_math_alu_top
// Signed 32-bit ALU; operation chosen by a configuration register.
// One item at a time: busy drops in the cycle the result strobe is shown,
// and a new item is not taken before the current one is through. The
// radix-2 divider and the square-and-multiply loop work one bit per
// cycle; the binary gcd loop runs until one operand reaches zero.
// Synchronous active-low reset clears the sequencer, strobe and operation
// (add). The result strobe lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module integer_math_alu_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_cfg_we,
    input  wire logic [4:0]                    i_cfg_wdata,
    input  wire logic signed [ima_pkg::DW-1:0] i_operand_a,
    input  wire logic signed [ima_pkg::DW-1:0] i_operand_b,
    input  wire logic signed [ima_pkg::DW-1:0] i_operand_c,
    output logic signed [ima_pkg::DW-1:0]      o_result,
    output logic                               o_result_valid
);

    ima_pkg::t_cmd    cmd;
    ima_pkg::t_status status;

    ima_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    ima_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_operand_c    (i_operand_c),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule
`default_nettype wire

>>> sv/ima_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ima_ctrl
// Sequencer: walks each operation through its datapath steps and counts
// divider and power iterations.
// ----------------------------------------------------------------------------
module ima_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire ima_pkg::t_status i_status,
    output ima_pkg::t_cmd         o_cmd,
    output logic                  o_busy
);

    ima_pkg::t_state r_state, n_state;
    logic [ima_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic last;

    assign last = (r_cnt == ima_pkg::CNT_W'(ima_pkg::DW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ima_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ima_pkg::S_IDLE: begin
                n_cnt = '0;
                if (i_start) begin
                    case (i_status.cls)
                        ima_pkg::C_MUL: n_state = ima_pkg::S_MUL;
                        ima_pkg::C_DIV: n_state = ima_pkg::S_DIV;
                        ima_pkg::C_POW: n_state = ima_pkg::S_POW;
                        ima_pkg::C_GCD: n_state = ima_pkg::S_GCD;
                        default:        n_state = ima_pkg::S_SIMPLE;
                    endcase
                end
            end
            ima_pkg::S_SIMPLE: n_state = ima_pkg::S_IDLE;
            ima_pkg::S_MUL:    n_state = ima_pkg::S_MADD;
            ima_pkg::S_MADD:   n_state = ima_pkg::S_IDLE;
            ima_pkg::S_DIV, ima_pkg::S_POW, ima_pkg::S_LDIV: begin
                n_cnt = r_cnt + 1'b1;
                if (last) begin
                    n_cnt = '0;
                    case (r_state)
                        ima_pkg::S_DIV: n_state = ima_pkg::S_FIX;
                        ima_pkg::S_POW: n_state = ima_pkg::S_POUT;
                        default:        n_state = ima_pkg::S_LMUL;
                    endcase
                end
            end
            ima_pkg::S_FIX:  n_state = ima_pkg::S_DOUT;
            ima_pkg::S_DOUT: n_state = ima_pkg::S_IDLE;
            ima_pkg::S_POUT: n_state = ima_pkg::S_IDLE;
            ima_pkg::S_GCD: begin
                if (i_status.gcd_done)
                    n_state = i_status.is_lcm ? ima_pkg::S_LPREP : ima_pkg::S_GOUT;
            end
            ima_pkg::S_GOUT:  n_state = ima_pkg::S_IDLE;
            ima_pkg::S_LPREP: n_state = ima_pkg::S_LDIV;
            ima_pkg::S_LMUL:  n_state = ima_pkg::S_LOUT;
            ima_pkg::S_LOUT:  n_state = ima_pkg::S_IDLE;
            default:          n_state = ima_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd  = ima_pkg::CMD_NONE;
        o_busy = (r_state != ima_pkg::S_IDLE);
        case (r_state)
            ima_pkg::S_IDLE:   o_cmd = i_start ? ima_pkg::CMD_LOAD : ima_pkg::CMD_NONE;
            ima_pkg::S_SIMPLE: o_cmd = ima_pkg::CMD_SIMPLE_OUT;
            ima_pkg::S_MUL:    o_cmd = ima_pkg::CMD_MUL;
            ima_pkg::S_MADD:   o_cmd = ima_pkg::CMD_MADD_OUT;
            ima_pkg::S_DIV:    o_cmd = ima_pkg::CMD_DIV_STEP;
            ima_pkg::S_LDIV:   o_cmd = ima_pkg::CMD_DIV_STEP;
            ima_pkg::S_FIX:    o_cmd = ima_pkg::CMD_DIV_FIX;
            ima_pkg::S_DOUT:   o_cmd = ima_pkg::CMD_DIV_OUT;
            ima_pkg::S_POW:    o_cmd = ima_pkg::CMD_POW_STEP;
            ima_pkg::S_POUT:   o_cmd = ima_pkg::CMD_POW_OUT;
            ima_pkg::S_GCD:
                o_cmd = i_status.gcd_done ? ima_pkg::CMD_NONE : ima_pkg::CMD_GCD_STEP;
            ima_pkg::S_GOUT:   o_cmd = ima_pkg::CMD_GCD_OUT;
            ima_pkg::S_LPREP:  o_cmd = ima_pkg::CMD_LCM_PREP;
            ima_pkg::S_LMUL:   o_cmd = ima_pkg::CMD_LCM_MUL;
            ima_pkg::S_LOUT:   o_cmd = ima_pkg::CMD_LCM_OUT;
            default:           o_cmd = ima_pkg::CMD_NONE;
        endcase
    end

endmodule
`default_nettype wire

>>> sv/ima_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ima_dp
// Datapath: operand and operation registers, radix-2 divider, binary gcd,
// square-and-multiply power, multiplier and result register.
// ----------------------------------------------------------------------------
module ima_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [4:0]                   i_cfg_wdata,
    input  wire logic signed [ima_pkg::DW-1:0] i_operand_a,
    input  wire logic signed [ima_pkg::DW-1:0] i_operand_b,
    input  wire logic signed [ima_pkg::DW-1:0] i_operand_c,
    input  wire ima_pkg::t_cmd                i_cmd,
    output ima_pkg::t_status                  o_status,
    output logic signed [ima_pkg::DW-1:0]     o_result,
    output logic                              o_result_valid
);

    localparam int DW = ima_pkg::DW;

    logic [4:0]            r_op;
    logic [DW-1:0]         r_a, r_b, r_c;
    logic [DW-1:0]         r_x, r_y, r_e, r_rem, r_prod;
    logic [ima_pkg::K_W-1:0] r_k;
    logic [DW-1:0]         r_res;
    logic                  r_valid;

    logic [DW:0]   trial;
    logic          fits;
    logic [DW-1:0] gcd_val, simple_res, div_res, pow_res, rdiff;
    logic          nq, rnz, inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_op <= ima_pkg::OP_ADD;
        else if (i_cfg_we)
            r_op <= i_cfg_wdata;
    end

    assign o_status.cls      = ima_pkg::op_class(r_op);
    assign o_status.is_lcm   = (r_op == ima_pkg::OP_LCM);
    assign o_status.gcd_done = (r_x == '0) || (r_y == '0);

    // divider step
    assign trial = {r_rem, r_x[DW-1]};
    assign fits  = (trial >= {1'b0, r_y});

    assign gcd_val = (r_x | r_y) << r_k;

    // quotient rounding
    assign nq    = r_a[DW-1] ^ r_b[DW-1];
    assign rnz   = (r_rem != '0);
    assign rdiff = r_y - r_rem;
    always_comb begin
        case (r_op)
            ima_pkg::OP_DIVFLOOR: inc = rnz && nq;
            ima_pkg::OP_DIVCEIL:  inc = rnz && !nq;
            ima_pkg::OP_DIVROUND: inc = rnz && (r_rem >= rdiff);
            default:              inc = 1'b0;
        endcase
    end

    always_comb begin
        case (r_op)
            ima_pkg::OP_ADD:  simple_res = r_a + r_b;
            ima_pkg::OP_SUB:  simple_res = r_a - r_b;
            ima_pkg::OP_ABS:  simple_res = ima_pkg::mag(r_a);
            ima_pkg::OP_SIGN: simple_res = (r_a == '0) ? '0 :
                                           (r_a[DW-1] ? '1 : DW'(1));
            ima_pkg::OP_MIN:  simple_res = ($signed(r_a) < $signed(r_b)) ? r_a : r_b;
            ima_pkg::OP_MAX:  simple_res = ($signed(r_a) > $signed(r_b)) ? r_a : r_b;
            ima_pkg::OP_NEG:  simple_res = DW'(0) - r_a;
            default:          simple_res = '0;
        endcase
    end

    always_comb begin
        if (r_b == '0) begin
            div_res = '0;
        end else begin
            case (r_op)
                ima_pkg::OP_FMOD: begin
                    if (!rnz)
                        div_res = '0;
                    else if (r_a[DW-1] == r_b[DW-1])
                        div_res = ima_pkg::sgn(r_a[DW-1], r_rem);
                    else
                        div_res = ima_pkg::sgn(r_b[DW-1], r_e);
                end
                ima_pkg::OP_MOD: div_res = ima_pkg::sgn(r_a[DW-1], r_rem);
                default:         div_res = ima_pkg::sgn(nq, r_x);
            endcase
        end
    end

    // negative exponent: only bases of one and minus one survive truncation
    always_comb begin
        if (!r_b[DW-1])
            pow_res = r_x;
        else if (r_a == DW'(1))
            pow_res = DW'(1);
        else if (r_a == '1)
            pow_res = r_b[0] ? '1 : DW'(1);
        else
            pow_res = '0;
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            ima_pkg::CMD_LOAD: begin
                r_a   <= i_operand_a;
                r_b   <= i_operand_b;
                r_c   <= i_operand_c;
                r_rem <= '0;
                r_k   <= '0;
                if (ima_pkg::op_class(r_op) == ima_pkg::C_POW) begin
                    r_x <= DW'(1);
                    r_y <= i_operand_a;
                    r_e <= i_operand_b;
                end else begin
                    r_x <= ima_pkg::mag(i_operand_a);
                    r_y <= ima_pkg::mag(i_operand_b);
                end
            end
            ima_pkg::CMD_MUL: r_prod <= r_a * r_b;
            ima_pkg::CMD_DIV_STEP: begin
                r_rem <= fits ? DW'(trial - {1'b0, r_y}) : trial[DW-1:0];
                r_x   <= {r_x[DW-2:0], fits};
            end
            ima_pkg::CMD_DIV_FIX: begin
                r_x <= r_x + DW'(inc);
                r_e <= rdiff;
            end
            ima_pkg::CMD_POW_STEP: begin
                if (r_e[0])
                    r_x <= r_x * r_y;
                r_y <= r_y * r_y;
                r_e <= r_e >> 1;
            end
            ima_pkg::CMD_GCD_STEP: begin
                if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1;
                    r_y <= r_y >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x >= r_y) begin
                    r_x <= r_x - r_y;
                end else begin
                    r_y <= r_y - r_x;
                end
            end
            ima_pkg::CMD_LCM_PREP: begin
                r_x   <= ima_pkg::mag(r_a);
                r_y   <= gcd_val;
                r_e   <= ima_pkg::mag(r_b);
                r_rem <= '0;
            end
            ima_pkg::CMD_LCM_MUL: r_prod <= r_x * r_e;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            ima_pkg::CMD_SIMPLE_OUT: r_res <= simple_res;
            ima_pkg::CMD_MADD_OUT:
                r_res <= (r_op == ima_pkg::OP_MADD) ? r_prod + r_c : r_prod;
            ima_pkg::CMD_DIV_OUT: r_res <= div_res;
            ima_pkg::CMD_POW_OUT: r_res <= pow_res;
            ima_pkg::CMD_GCD_OUT: r_res <= gcd_val;
            ima_pkg::CMD_LCM_OUT:
                r_res <= ((r_a == '0) || (r_b == '0)) ? '0 : r_prod;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_cmd)
                ima_pkg::CMD_SIMPLE_OUT, ima_pkg::CMD_MADD_OUT, ima_pkg::CMD_DIV_OUT,
                ima_pkg::CMD_POW_OUT, ima_pkg::CMD_GCD_OUT, ima_pkg::CMD_LCM_OUT:
                    r_valid <= 1'b1;
                default: r_valid <= 1'b0;
            endcase
        end
    end

    assign o_result       = r_res;
    assign o_result_valid = r_valid;

endmodule
`default_nettype wire
